// ===== src/sha256_stream_hasher_assert.svh =====
// Assertion macros for the hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// implication checked on every edge outside reset
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  typedef enum logic [2:0] {
    StIdle,    // taking bytes
    StRound,   // compression rounds
    StFold,    // add working vars into hash
    StPad,     // writing pad/zero/length bytes
    StEmit     // sending digest words
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic       buf_we;      // write one byte into the block buffer
    logic [5:0] buf_addr;
    logic [7:0] buf_data;
    logic       load_vars;   // copy hash into working vars
    logic       do_round;
    logic [5:0] round_idx;
    logic       fold;
    logic       init_hash;
    logic [2:0] out_idx;
  } dp_cmd_t;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha_stream_if.sv =====
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels carrying message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule window, working variables and hash words.
// ----------------------------------------------------------------------------
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output logic [31:0] hash_word_o
);
  // Buffer holds 32-bit words; a byte write is a read-modify-free lane write,
  // so we keep four byte RAMs of 16 entries each.
  localparam int unsigned WordDepth = BlockBytes / 4;
  localparam int unsigned WaW = $clog2(WordDepth);

  logic [7:0]  lane_rd [4];
  logic [WaW-1:0] rd_addr;
  logic [31:0] w_q [16];      // schedule window, w_q[0] is the oldest word
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [31:0] w_cur, w_new, s0, s1, t1, t2;
  logic [5:0]  rnd_next;

  // prefetch the word for the next round so the registered read lines up
  assign rnd_next = cmd_i.load_vars ? 6'd0 : cmd_i.round_idx + 6'd1;
  assign rd_addr  = rnd_next[WaW-1:0];

  // lane 0 holds the most significant byte of each word
  for (genvar l = 0; l < 4; l++) begin : g_lane
    sha_ram #(.Width(8), .Depth(WordDepth)) u_lane (
      .clk_i   (clk_i),
      .we_i    (cmd_i.buf_we && (cmd_i.buf_addr[1:0] == 2'(l))),
      .waddr_i (cmd_i.buf_addr[5:2]),
      .wdata_i (cmd_i.buf_data),
      .raddr_i (rd_addr),
      .rdata_o (lane_rd[l])
    );
  end

  // rounds 0..15 take buffer words, later ones the schedule recurrence
  assign s0    = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign w_cur = (cmd_i.round_idx < 6'd16) ?
                 {lane_rd[0], lane_rd[1], lane_rd[2], lane_rd[3]} : w_new;

  assign t1 = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25)) +
              ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[cmd_i.round_idx] + w_cur;
  assign t2 = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22)) +
              ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // window: w_q[k] = w[i-16+k]; after round i holds w[i-15..i]
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_round) begin
      for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
      w_q[15] <= w_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vars) begin
      v_q <= h_q;
    end else if (cmd_i.do_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= InitHash;
    end else if (cmd_i.init_hash) begin
      h_q <= InitHash;
    end else if (cmd_i.fold) begin
      for (int k = 0; k < 8; k++) h_q[k] <= h_q[k] + v_q[k];
    end
  end

  assign hash_word_o = h_q[cmd_i.out_idx];
endmodule

// ===== src/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, round counting, padding and digest emission.
// ----------------------------------------------------------------------------
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_bval_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_idx_o,
  output dp_cmd_t    cmd_o
);
  `include "sha256_stream_hasher_assert.svh"

  ctrl_state_e state_q, state_d;
  logic [5:0]  fill_q, fill_d;        // buffer fill / pad pointer
  logic [63:0] total_q, total_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;          // message ending, pad pending
  logic        lenblk_q, lenblk_d;    // current pad block carries the length
  logic [2:0]  oidx_q, oidx_d;
  logic        acc;
  logic [63:0] bits;
  logic [7:0]  pad_byte;

  assign acc  = in_valid_i && in_ready_o;
  assign bits = {total_q[60:0], 3'b000};

  // pad pointer: byte 56..63 of a length block carries the bit count
  always_comb begin
    pad_byte = '0;
    if (lenblk_q && fill_q >= LenOffset)
      pad_byte = bits[8*(7 - fill_q[2:0]) +: 8];
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    total_d  = total_q;
    rnd_d    = rnd_q;
    fin_d    = fin_q;
    lenblk_d = lenblk_q;
    oidx_d   = oidx_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_bval_i) begin
            fill_d  = fill_q + 6'd1;
            total_d = total_q + 64'd1;
          end
          if (in_bval_i && fill_q == 6'd63) begin
            fin_d   = in_last_i;
            state_d = StRound;
            rnd_d   = '0;
          end else if (in_last_i) begin
            fin_d   = 1'b1;
            state_d = StPad;
            // pad byte goes at the new fill position, written in StPad
            lenblk_d = ((in_bval_i ? fill_q + 6'd1 : fill_q) < LenOffset);
          end
        end
      end
      StPad: begin
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = StRound;
          rnd_d   = '0;
        end
      end
      StRound: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = StFold;
      end
      StFold: begin
        if (!fin_q) begin
          state_d = StIdle;
        end else if (!lenblk_q) begin
          lenblk_d = 1'b1;
          state_d  = StPad;
        end else begin
          state_d = StEmit;
          oidx_d  = '0;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d  = StIdle;
            fin_d    = 1'b0;
            lenblk_d = 1'b0;
            total_d  = '0;
            fill_d   = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // StPad starts with a pad byte only on the first pad pass: track via marker
  logic padmark_q, padmark_d;
  always_comb begin
    padmark_d = padmark_q;
    if (state_q == StIdle && acc && in_last_i) padmark_d = 1'b1;
    if (state_q == StPad) padmark_d = 1'b0;
    if (state_q == StRound && fin_q && padmark_q) padmark_d = 1'b1;
  end

  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = oidx_q;
    case (state_q)
      StIdle: begin
        in_ready_o     = 1'b1;
        cmd_o.buf_we   = in_valid_i && in_bval_i;
        cmd_o.buf_addr = fill_q;
        cmd_o.buf_data = in_byte_i;
        cmd_o.load_vars = 1'b1;
      end
      StPad: begin
        cmd_o.buf_we    = 1'b1;
        cmd_o.buf_addr  = fill_q;
        cmd_o.buf_data  = padmark_q ? PadByte : pad_byte;
        cmd_o.load_vars = 1'b1;
      end
      StRound:  cmd_o.do_round = 1'b1;
      StFold:   cmd_o.fold     = 1'b1;
      StEmit: begin
        out_valid_o     = 1'b1;
        cmd_o.init_hash = out_ready_i && (oidx_q == 3'd7);
      end
      default: ;
    endcase
  end

  assign out_idx_o = oidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      total_q   <= '0;
      rnd_q     <= '0;
      fin_q     <= 1'b0;
      lenblk_q  <= 1'b0;
      oidx_q    <= '0;
      padmark_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      total_q   <= total_d;
      rnd_q     <= rnd_d;
      fin_q     <= fin_d;
      lenblk_q  <= lenblk_d;
      oidx_q    <= oidx_d;
      padmark_q <= padmark_d;
    end
  end

  `SHA_ASSERT_IMP(a_no_in_busy, clk_i, rst_ni, state_q != StIdle, !in_ready_o)
  `SHA_ASSERT_NXT(a_round_end, clk_i, rst_ni, state_q == StRound && rnd_q == 6'd63,
                  state_q == StFold)
  `SHA_ASSERT_IMP(a_emit_len, clk_i, rst_ni, state_q == StEmit, lenblk_q && fin_q)
endmodule

// ===== src/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256: buffers, pads and compresses, then emits the digest.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_req    in   data_byte[8], byte_valid, last_byte
// out_req   out  digest_word[32], word_index[3], last_word
//
// One request a cycle while a block fills; a full block then runs 64 rounds
// on one round unit and one fold, with input held off.
// A last request adds pad writes up to the block end (one per byte), one or
// two compressions, then eight digest words, each held until taken.
// Reset is asynchronous and restores the initial hash.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  sha_in_if.sink    in_req,
  sha_out_if.source out_req
);
  dp_cmd_t     cmd;
  logic [31:0] hword;
  logic [2:0]  oidx;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_ready_o  (in_req.ready),
    .in_byte_i   (in_req.data_byte),
    .in_bval_i   (in_req.byte_valid),
    .in_last_i   (in_req.last_byte),
    .out_valid_o (out_req.valid),
    .out_ready_i (out_req.ready),
    .out_idx_o   (oidx),
    .cmd_o       (cmd)
  );

  sha_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .hash_word_o (hword)
  );

  assign out_req.digest_word = hword;
  assign out_req.word_index  = oidx;
  assign out_req.last_word   = (oidx == 3'd7);
endmodule

// ===== tb/sha_hash_scoreboard.sv =====
// ----------------------------------------------------------------------------
// sha_hash_scoreboard
// Predicts SHA-256 digests from accepted byte requests and checks the words.
// ----------------------------------------------------------------------------
package sha_hash_scoreboard_pkg;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  class digest_scoreboard;
    logic [31:0]  hash_state [8];
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [63:0]  msg_bytes;
    digest_item_t pending_words [$];
    int unsigned  error_count;

    function new();
      error_count = 0;
      restart();
      foreach (blk[i]) blk[i] = 8'h00;
    endfunction

    function void restart();
      foreach (hash_state[i]) hash_state[i] = InitHash[i];
      fill      = 0;
      msg_bytes = '0;
    endfunction

    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, r;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        r  = w[i-15];
        s0 = {r[6:0], r[31:7]} ^ {r[17:0], r[31:18]} ^ (r >> 3);
        r  = w[i-2];
        s1 = {r[16:0], r[31:17]} ^ {r[18:0], r[31:19]} ^ (r >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      foreach (v[i]) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
        r  = v[4];
        t1 = v[7] + ({r[5:0], r[31:6]} ^ {r[10:0], r[31:11]} ^ {r[24:0], r[31:25]})
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
        r  = v[0];
        t2 = ({r[1:0], r[31:2]} ^ {r[12:0], r[31:13]} ^ {r[21:0], r[31:22]})
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (hash_state[i]) hash_state[i] += v[i];
    endfunction

    // accepted byte request
    function void note_request(logic [7:0] data, logic bvalid, logic lastb);
      logic [63:0]  bit_len;
      int unsigned  used;
      digest_item_t word;
      if (bvalid) begin
        blk[fill] = data;
        msg_bytes++;
        fill++;
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
      end
      if (!lastb) return;
      bit_len   = msg_bytes << 3;
      blk[fill] = PadByte;
      used      = fill + 1;
      if (used > LenOffset) begin
        for (int i = used; i < 64; i++) blk[i] = 8'h00;
        compress_block();
        used = 0;
      end
      for (int i = used; i < LenOffset; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = hash_state[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        pending_words.push_back(word);
      end
      restart();
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      error_count++;
    endtask

    task check_word(digest_item_t got);
      digest_item_t exp_word;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected digest word %h", got.digest_word));
        return;
      end
      exp_word = pending_words.pop_front();
      if (got.digest_word !== exp_word.digest_word)
        report($sformatf("word %0d: got %h want %h", exp_word.word_index,
                         got.digest_word, exp_word.digest_word));
      if (got.word_index !== exp_word.word_index)
        report($sformatf("index: got %0d want %0d", got.word_index, exp_word.word_index));
      if (got.last_word !== exp_word.last_word)
        report($sformatf("last flag: got %b want %b", got.last_word, exp_word.last_word));
    endtask
  endclass
endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams random and directed messages into the hasher, checks every digest.
// ----------------------------------------------------------------------------
module testbench;
  import sha_hash_scoreboard_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;
  int   cycle_count;

  sha_in_if  in_req ();
  sha_out_if out_req ();

  digest_scoreboard digest_sb;

  sha256_stream_hasher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (in_req.sink),
    .out_req(out_req.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    out_req.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_req.valid && out_req.ready)
        digest_sb.check_word('{out_req.digest_word, out_req.word_index,
                               out_req.last_word});
      out_req.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high between back-to-back requests
  task automatic send_request(logic [7:0] data, logic bvalid, logic lastb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_req.valid      <= 1'b1;
    in_req.data_byte  <= data;
    in_req.byte_valid <= bvalid;
    in_req.last_byte  <= lastb;
    do @(posedge clk_i); while (!in_req.ready);
    digest_sb.note_request(data, bvalid, lastb);
  endtask

  task automatic send_message(int unsigned len, bit idle_noise);
    for (int i = 0; i < len; i++) begin
      if (idle_noise && $urandom_range(9) == 0)
        send_request(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1))
        send_request(8'($urandom), 1'b1, 1'b1);
      else
        send_request(8'($urandom), 1'b1, 1'b0);
    end
    if (len == 0 || !in_req.last_byte) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (digest_sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    digest_sb         = new();
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off          = 1'b0;
    rst_ni            = 1'b0;
    in_req.valid      = 1'b0;
    in_req.data_byte  = '0;
    in_req.byte_valid = 1'b0;
    in_req.last_byte  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, extremes, pad boundaries
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 21 : 59) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 21 : 59) : 0;
      for (int m = 0; m < 5; m++)
        send_message((m == 4) ? $urandom_range(30, 70) : $urandom_range(0, 6), 1'b1);
    end

    // long receiver hold-off while messages keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        for (int c = 0; c < 600; c++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int m = 0; m < 3; m++) send_message($urandom_range(1, 5), 1'b0);
    join
    in_req.valid <= 1'b0;
    wait_drained();

    if (digest_sb.error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/sha_pkg.sv
src/sha_stream_if.sv
src/sha_ram.sv
src/sha_datapath.sv
src/sha_ctrl.sv
src/sha256_stream_hasher.sv
tb/sha_hash_scoreboard.sv
tb/testbench.sv
